FILE: design/wsm_pkg.sv
// ----------------------------------------------------------------------------
// wsm_pkg
// Shared types, constants and time helpers for the weekly schedule matcher.
// ----------------------------------------------------------------------------
package wsm_pkg;

    // field widths
    localparam int OP_W     = 2;
    localparam int SLOT_W   = 3;
    localparam int DAYS_W   = 7;
    localparam int DAY_W    = 3;
    localparam int HOUR_W   = 5;
    localparam int MINUTE_W = 6;
    localparam int MASK_W   = 8;
    localparam int THR_W    = 10;
    localparam int POS_W    = 14;
    localparam int COUNT_W  = 6;

    // calendar constants
    localparam int MIN_PER_HOUR = 60;
    localparam int HOUR_PER_DAY = 24;
    localparam int DAY_PER_WEEK = 7;
    localparam int MIN_PER_DAY  = 1440;
    localparam int MIN_PER_WEEK = 10080;

    // reset value of the backward threshold
    localparam logic [THR_W-1:0] THR_RESET = THR_W'(10);

    // replay results beyond this count are dropped
    localparam int MAX_REPLAY_RES = 56;

    // default table depth
    localparam int ENTRY_COUNT_DEF = 8;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD = 2'd0,
        OP_TICK = 2'd1,
        OP_SET  = 2'd2
    } t_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SET_POS,
        ST_SET_CMP,
        ST_STEP,
        ST_SCAN,
        ST_EMIT,
        ST_FINAL
    } t_state;

    typedef struct packed {
        logic [DAY_W-1:0]    day;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } t_time;

    typedef struct packed {
        logic [DAYS_W-1:0]   days;
        logic [HOUR_W-1:0]   hour;
        logic [MINUTE_W-1:0] minute;
    } t_entry;

    typedef struct packed {
        logic [MASK_W-1:0]   match_mask;
        t_time               at;
        logic                last;
    } t_result;

    // one minute forward with minute, hour and day wrap
    function automatic t_time advance_minute(input t_time t);
        t_time r;
        r = t;
        if (32'(t.minute) >= MIN_PER_HOUR - 1) begin
            r.minute = '0;
            if (32'(t.hour) >= HOUR_PER_DAY - 1) begin
                r.hour = '0;
                if (32'(t.day) >= DAY_PER_WEEK - 1) begin
                    r.day = '0;
                end else begin
                    r.day = t.day + DAY_W'(1);
                end
            end else begin
                r.hour = t.hour + HOUR_W'(1);
            end
        end else begin
            r.minute = t.minute + MINUTE_W'(1);
        end
        return r;
    endfunction

    // minute of the week
    function automatic logic [POS_W-1:0] week_pos(input t_time t);
        return POS_W'(t.day) * POS_W'(MIN_PER_DAY)
             + POS_W'(t.hour) * POS_W'(MIN_PER_HOUR)
             + POS_W'(t.minute);
    endfunction

endpackage

FILE: design/wsm_sched_mem.sv
// ----------------------------------------------------------------------------
// wsm_sched_mem
// Schedule table memory: one write port, one read port with registered data.
// Per-entry valid bits make unwritten entries read as all zero.
// ----------------------------------------------------------------------------
module wsm_sched_mem #(
    parameter int ENTRY_COUNT = wsm_pkg::ENTRY_COUNT_DEF,
    localparam int IdxW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_wr_en,
    input  logic [IdxW-1:0]   i_wr_addr,
    input  wsm_pkg::t_entry   i_wr_data,
    input  logic              i_rd_en,
    input  logic [IdxW-1:0]   i_rd_addr,
    output wsm_pkg::t_entry   o_rd_data
);

    wsm_pkg::t_entry r_mem [ENTRY_COUNT];
    logic [ENTRY_COUNT-1:0] r_valid;
    wsm_pkg::t_entry r_rd_data;
    logic r_rd_valid;

    // storage array
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    // valid bits, cleared at reset
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_wr_en) begin
                r_valid[i_wr_addr] <= 1'b1;
            end
            if (i_rd_en) begin
                r_rd_valid <= r_valid[i_rd_addr];
            end
        end
    end

    // unwritten entry reads as zero
    assign o_rd_data = r_rd_valid ? r_rd_data : '0;

endmodule

FILE: design/wsm_out_reg.sv
// ----------------------------------------------------------------------------
// wsm_out_reg
// Single result register on the output channel; decouples the sequencer
// from a stalled receiver.
// ----------------------------------------------------------------------------
module wsm_out_reg (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_push,
    input  wsm_pkg::t_result  i_data,
    output logic              o_free,
    output logic              o_valid,
    output wsm_pkg::t_result  o_data,
    input  logic              i_ready
);

    logic             r_valid;
    wsm_pkg::t_result r_data;

    // free when empty or the held result transfers this cycle
    assign o_free = !r_valid || i_ready;

    // valid flag
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_push) begin
            r_valid <= 1'b1;
        end else if (i_ready) begin
            r_valid <= 1'b0;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_data <= i_data;
        end
    end

    assign o_valid = r_valid;
    assign o_data  = r_data;

endmodule

FILE: design/weekly_schedule_matcher_top.sv
// ----------------------------------------------------------------------------
// weekly_schedule_matcher_top
// Week clock with a schedule table; reports matching entries per minute.
// ----------------------------------------------------------------------------
// Usage:
//   input channel (i_valid/o_ready) carries one command: load entry, minute
//   tick or set clock. o_ready is high only while the sequencer is idle.
//   output channel (o_valid/i_ready) carries results; last marks the final
//   result of a command. config channel (i_cfg_valid/o_cfg_ready) writes the
//   backward threshold and is always ready; write it only when idle.
// Timing:
//   a load gives no result. each stepped minute is bound by the one read
//   port of the table memory, which is scanned one entry per cycle. a set
//   either sets the clock directly or replays minute by minute up to the
//   target. the first result appears in the cycle after it is computed,
//   from the output register.
// Reset:
//   synchronous; clock goes to day 0 00:00, all entries read as empty,
//   threshold returns to 10. no clearing pass is needed.
// Stall:
//   a held result blocks the next result; the sequencer waits, nothing drops.
// ----------------------------------------------------------------------------
module weekly_schedule_matcher_top #(
    parameter int ENTRY_COUNT = wsm_pkg::ENTRY_COUNT_DEF
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    // command channel
    input  logic                           i_valid,
    output logic                           o_ready,
    input  logic [wsm_pkg::OP_W-1:0]       i_operation,
    input  logic [wsm_pkg::SLOT_W-1:0]     i_entry_slot,
    input  logic [wsm_pkg::DAYS_W-1:0]     i_entry_days,
    input  logic [wsm_pkg::HOUR_W-1:0]     i_entry_hour,
    input  logic [wsm_pkg::MINUTE_W-1:0]   i_entry_minute,
    input  logic [wsm_pkg::DAY_W-1:0]      i_new_day,
    input  logic [wsm_pkg::HOUR_W-1:0]     i_new_hour,
    input  logic [wsm_pkg::MINUTE_W-1:0]   i_new_minute,
    // result channel
    output logic                           o_valid,
    input  logic                           i_ready,
    output logic [wsm_pkg::MASK_W-1:0]     o_match_mask,
    output logic [wsm_pkg::DAY_W-1:0]      o_at_day,
    output logic [wsm_pkg::HOUR_W-1:0]     o_at_hour,
    output logic [wsm_pkg::MINUTE_W-1:0]   o_at_minute,
    output logic                           o_last,
    // config channel
    input  logic                           i_cfg_valid,
    output logic                           o_cfg_ready,
    input  logic [wsm_pkg::THR_W-1:0]      i_cfg_data
);

    localparam int IdxW = (ENTRY_COUNT > 1) ? $clog2(ENTRY_COUNT) : 1;

    wsm_pkg::t_state r_state, n_state;
    wsm_pkg::t_time  r_clock, n_clock;
    wsm_pkg::t_time  r_target, n_target;
    logic [wsm_pkg::POS_W-1:0]   r_now_pos, n_now_pos;
    logic [wsm_pkg::POS_W-1:0]   r_tgt_pos, n_tgt_pos;
    logic [wsm_pkg::MASK_W-1:0]  r_mask, n_mask;
    logic [IdxW-1:0]             r_scan_idx, n_scan_idx;
    logic [wsm_pkg::COUNT_W-1:0] r_count, n_count;
    logic                        r_is_tick, n_is_tick;
    logic [wsm_pkg::THR_W-1:0]   r_threshold;

    logic             in_fire;
    logic             mem_wr_en;
    wsm_pkg::t_entry  mem_wr_data;
    logic             mem_rd_en;
    logic [IdxW-1:0]  mem_rd_addr;
    wsm_pkg::t_entry  mem_rd_data;
    logic             out_push;
    logic             out_free;
    wsm_pkg::t_result out_data;
    wsm_pkg::t_result out_q;
    logic             entry_hit;
    logic             push_needed;
    logic [wsm_pkg::POS_W-1:0] behind;

    assign in_fire = i_valid && o_ready;
    assign o_ready = (r_state == wsm_pkg::ST_IDLE);

    // threshold register
    assign o_cfg_ready = 1'b1;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_threshold <= wsm_pkg::THR_RESET;
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_threshold <= i_cfg_data;
        end
    end

    // schedule table write on a load transfer
    assign mem_wr_en = in_fire
                    && (wsm_pkg::t_op'(i_operation) == wsm_pkg::OP_LOAD)
                    && (32'(i_entry_slot) < ENTRY_COUNT);
    assign mem_wr_data = '{days: i_entry_days, hour: i_entry_hour, minute: i_entry_minute};

    wsm_sched_mem #(
        .ENTRY_COUNT (ENTRY_COUNT)
    ) u_sched_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (IdxW'(i_entry_slot)),
        .i_wr_data (mem_wr_data),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (mem_rd_addr),
        .o_rd_data (mem_rd_data)
    );

    // entry compare against the current minute
    assign entry_hit = mem_rd_data.days[r_clock.day]
                    && (mem_rd_data.hour == r_clock.hour)
                    && (mem_rd_data.minute == r_clock.minute);

    // distance behind, with weekly wrap
    assign behind = (r_now_pos >= r_tgt_pos)
                  ? (r_now_pos - r_tgt_pos)
                  : (r_now_pos + wsm_pkg::POS_W'(wsm_pkg::MIN_PER_WEEK) - r_tgt_pos);

    assign push_needed = r_is_tick
                      || ((r_mask != '0) && (32'(r_count) < wsm_pkg::MAX_REPLAY_RES));

    // sequencer state registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= wsm_pkg::ST_IDLE;
            r_clock    <= '0;
            r_count    <= '0;
            r_is_tick  <= 1'b0;
            r_scan_idx <= '0;
        end else begin
            r_state    <= n_state;
            r_clock    <= n_clock;
            r_count    <= n_count;
            r_is_tick  <= n_is_tick;
            r_scan_idx <= n_scan_idx;
        end
    end

    // sequencer working values
    always_ff @(posedge i_clk) begin
        r_target  <= n_target;
        r_now_pos <= n_now_pos;
        r_tgt_pos <= n_tgt_pos;
        r_mask    <= n_mask;
    end

    // sequencer next state and outputs
    always_comb begin
        n_state     = r_state;
        n_clock     = r_clock;
        n_target    = r_target;
        n_now_pos   = r_now_pos;
        n_tgt_pos   = r_tgt_pos;
        n_mask      = r_mask;
        n_scan_idx  = r_scan_idx;
        n_count     = r_count;
        n_is_tick   = r_is_tick;
        mem_rd_en   = 1'b0;
        mem_rd_addr = '0;
        out_push    = 1'b0;
        out_data    = '{match_mask: r_mask, at: r_clock, last: r_is_tick};

        case (r_state)
            wsm_pkg::ST_IDLE: begin
                if (in_fire) begin
                    case (wsm_pkg::t_op'(i_operation))
                        wsm_pkg::OP_TICK: begin
                            n_is_tick = 1'b1;
                            n_state   = wsm_pkg::ST_STEP;
                        end
                        wsm_pkg::OP_SET: begin
                            n_is_tick = 1'b0;
                            n_target.day = (32'(i_new_day) > wsm_pkg::DAY_PER_WEEK - 1)
                                ? wsm_pkg::DAY_W'(wsm_pkg::DAY_PER_WEEK - 1) : i_new_day;
                            n_target.hour = (32'(i_new_hour) > wsm_pkg::HOUR_PER_DAY - 1)
                                ? wsm_pkg::HOUR_W'(wsm_pkg::HOUR_PER_DAY - 1) : i_new_hour;
                            n_target.minute = (32'(i_new_minute) > wsm_pkg::MIN_PER_HOUR - 1)
                                ? wsm_pkg::MINUTE_W'(wsm_pkg::MIN_PER_HOUR - 1)
                                : i_new_minute;
                            n_state = wsm_pkg::ST_SET_POS;
                        end
                        default: begin
                            n_state = wsm_pkg::ST_IDLE;
                        end
                    endcase
                end
            end
            // minute-of-week positions
            wsm_pkg::ST_SET_POS: begin
                n_now_pos = wsm_pkg::week_pos(r_clock);
                n_tgt_pos = wsm_pkg::week_pos(r_target);
                n_state   = wsm_pkg::ST_SET_CMP;
            end
            // direct set or replay
            wsm_pkg::ST_SET_CMP: begin
                if (behind < wsm_pkg::POS_W'(r_threshold)) begin
                    n_clock = r_target;
                    n_state = wsm_pkg::ST_FINAL;
                end else begin
                    n_count = '0;
                    n_state = wsm_pkg::ST_STEP;
                end
            end
            // advance one minute and start the table scan
            wsm_pkg::ST_STEP: begin
                n_clock     = wsm_pkg::advance_minute(r_clock);
                mem_rd_en   = 1'b1;
                mem_rd_addr = '0;
                n_scan_idx  = '0;
                n_mask      = '0;
                n_state     = wsm_pkg::ST_SCAN;
            end
            // one entry per cycle, next read issued ahead
            wsm_pkg::ST_SCAN: begin
                for (int b = 0; b < wsm_pkg::MASK_W; b++) begin
                    if (entry_hit && (32'(r_scan_idx) == b)) begin
                        n_mask[b] = 1'b1;
                    end
                end
                if (32'(r_scan_idx) >= ENTRY_COUNT - 1) begin
                    n_state = wsm_pkg::ST_EMIT;
                end else begin
                    mem_rd_en   = 1'b1;
                    mem_rd_addr = r_scan_idx + IdxW'(1);
                    n_scan_idx  = r_scan_idx + IdxW'(1);
                end
            end
            // report the minute if needed, then continue or finish
            wsm_pkg::ST_EMIT: begin
                if (!push_needed || out_free) begin
                    out_push = push_needed;
                    if (push_needed && !r_is_tick) begin
                        n_count = r_count + wsm_pkg::COUNT_W'(1);
                    end
                    if (r_is_tick) begin
                        n_state = wsm_pkg::ST_IDLE;
                    end else if (r_clock == r_target) begin
                        n_state = wsm_pkg::ST_FINAL;
                    end else begin
                        n_state = wsm_pkg::ST_STEP;
                    end
                end
            end
            // final time result of a set
            wsm_pkg::ST_FINAL: begin
                out_data = '{match_mask: '0, at: r_clock, last: 1'b1};
                if (out_free) begin
                    out_push = 1'b1;
                    n_state  = wsm_pkg::ST_IDLE;
                end
            end
            default: begin
                n_state = wsm_pkg::ST_IDLE;
            end
        endcase
    end

    wsm_out_reg u_out_reg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (out_push),
        .i_data  (out_data),
        .o_free  (out_free),
        .o_valid (o_valid),
        .o_data  (out_q),
        .i_ready (i_ready)
    );

    assign o_match_mask = out_q.match_mask;
    assign o_at_day     = out_q.at.day;
    assign o_at_hour    = out_q.at.hour;
    assign o_at_minute  = out_q.at.minute;
    assign o_last       = out_q.last;

`ifndef SYNTH
    // week clock stays within its calendar range
    a_clock_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (32'(r_clock.minute) < wsm_pkg::MIN_PER_HOUR)
        && (32'(r_clock.hour) < wsm_pkg::HOUR_PER_DAY)
        && (32'(r_clock.day) < wsm_pkg::DAY_PER_WEEK))
        else $error("week clock out of range");

    // replay result count never passes its cap
    a_count_cap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        32'(r_count) <= wsm_pkg::MAX_REPLAY_RES)
        else $error("replay result count over cap");

    // a result is only loaded into a free output register
    a_push_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        out_push |-> out_free)
        else $error("result pushed into a full output register");

    // new commands only enter while idle
    a_accept_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_fire |-> (r_state == wsm_pkg::ST_IDLE))
        else $error("command accepted while busy");
`endif

endmodule
